FILE: hdl/tvs_pkg.sv
package tvs_pkg;

  localparam int TAG_W   = 3;
  localparam int PAY_W   = 64;
  localparam int COUNT_W = 9;
  localparam int INDEX_W = 8;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_TYPE  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [TAG_W-1:0]   push_tag;
    logic [PAY_W-1:0]   push_payload;
    logic [COUNT_W-1:0] pop_count;
    logic [INDEX_W-1:0] depth_index;
    logic [TAG_W-1:0]   expected_tag;
    logic               strict_check;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [TAG_W-1:0]   read_tag;
    logic [PAY_W-1:0]   read_payload;
    logic               tag_matches;
    logic [COUNT_W-1:0] popped_count;
    logic [COUNT_W-1:0] size_after;
  } rsp_t;

endpackage

FILE: hdl/tvs_store.sv
module tvs_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [tvs_pkg::TAG_W-1:0] wr_tag,
  input  logic [tvs_pkg::PAY_W-1:0] wr_payload,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [tvs_pkg::TAG_W-1:0] rd_tag,
  output logic [tvs_pkg::PAY_W-1:0] rd_payload
);
  import tvs_pkg::*;

  logic [TAG_W+PAY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tag, wr_payload};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_tag, rd_payload} <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/tagged_value_stack.sv
// Tagged value operand stack, DEPTH entries of 3-bit tag plus 64-bit payload.
// Throughput: one transaction per cycle unless rsp_ready stalls the output.
// Stage 1 updates the size and accesses the entry memory, stage 2 forms the
// response from the read data and registers it for rsp_valid.
// Reset: synchronous, empties the stack and drops both pipeline stages;
// entry memory contents are not cleared.
module tagged_value_stack #(
  parameter int DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tvs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tvs_pkg::rsp_t rsp
);
  import tvs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = (SW > COUNT_W) ? SW : COUNT_W;

  typedef struct packed {
    cmd_e               cmd;
    status_e            status;
    logic               range_ok;
    logic [TAG_W-1:0]   expected_tag;
    logic               strict_check;
    logic [COUNT_W-1:0] popped_count;
    logic [COUNT_W-1:0] size_after;
  } s1_t;

  logic [SW-1:0] size;
  logic [SW-1:0] size_next;
  logic          s1_valid;
  s1_t           s1;
  s1_t           s1_next;
  rsp_t          rsp_next;

  logic          req_fire;
  logic          advance;
  logic          full;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] size_w;
  logic [CW-1:0] cnt_w;
  logic [CW-1:0] dep_w;
  logic [CW-1:0] pop_n;
  logic [CW-1:0] peek_idx;
  logic [CW-1:0] after_w;

  logic [TAG_W-1:0] rd_tag;
  logic [PAY_W-1:0] rd_payload;
  logic             tag_eq;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || advance;
  assign req_fire  = req_valid && req_ready;

  assign size_w   = CW'(size);
  assign cnt_w    = CW'(req.pop_count);
  assign dep_w    = CW'(req.depth_index);
  assign full     = (size == SW'(DEPTH));
  assign pop_n    = (cnt_w < size_w) ? cnt_w : size_w;
  assign peek_idx = size_w - CW'(1) - dep_w;
  assign rd_addr  = peek_idx[AW-1:0];

  always_comb begin
    size_next            = size;
    wr_en                = 1'b0;
    rd_en                = 1'b0;
    s1_next.cmd          = req.cmd;
    s1_next.status       = ST_OK;
    s1_next.range_ok     = 1'b0;
    s1_next.expected_tag = req.expected_tag;
    s1_next.strict_check = req.strict_check;
    s1_next.popped_count = '0;
    unique case (req.cmd)
      CMD_PUSH: begin
        if (full) begin
          s1_next.status = ST_FULL;
        end else begin
          wr_en     = req_fire;
          size_next = size + SW'(1);
        end
      end
      CMD_POP: begin
        size_next            = size - pop_n[SW-1:0];
        s1_next.popped_count = pop_n[COUNT_W-1:0];
      end
      CMD_PEEK: begin
        if (dep_w >= size_w) begin
          s1_next.status = ST_RANGE;
        end else begin
          s1_next.range_ok = 1'b1;
          rd_en            = req_fire;
        end
      end
      CMD_CLEAR: begin
        size_next = '0;
      end
    endcase
    after_w            = CW'(size_next);
    s1_next.size_after = after_w[COUNT_W-1:0];
  end

  tvs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (size[AW-1:0]),
    .wr_tag     (req.push_tag),
    .wr_payload (req.push_payload),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_tag     (rd_tag),
    .rd_payload (rd_payload)
  );

  assign tag_eq = (rd_tag == s1.expected_tag);

  always_comb begin
    rsp_next.status       = s1.status;
    rsp_next.read_tag     = '0;
    rsp_next.read_payload = '0;
    rsp_next.tag_matches  = 1'b0;
    rsp_next.popped_count = s1.popped_count;
    rsp_next.size_after   = s1.size_after;
    if (s1.cmd == CMD_PEEK && s1.range_ok) begin
      if (!tag_eq && s1.strict_check) begin
        rsp_next.status = ST_TYPE;
      end else begin
        rsp_next.read_tag     = rd_tag;
        rsp_next.read_payload = rd_payload;
        rsp_next.tag_matches  = tag_eq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= '0;
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        size <= size_next;
      end
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1 <= s1_next;
    end
    if (advance && s1_valid) begin
      rsp <= rsp_next;
    end
  end

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    size <= SW'(DEPTH))
    else $error("stack size above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.cmd == CMD_PUSH && !full |=> size == $past(size) + SW'(1))
    else $error("push did not grow stack");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.cmd == CMD_CLEAR |=> size == '0)
    else $error("clear left entries");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |->
      rsp.read_tag == '0 && rsp.read_payload == '0 && !rsp.tag_matches)
    else $error("failed transaction returned entry data");

endmodule

FILE: sim/tagged_value_stack_tb.sv
module tagged_value_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvs_pkg::*;

  localparam int STACK_DEPTH   = 256;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 64;
  localparam int ITEMS_PER_PHASE = 255;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct packed {
    req_t       rq;
    logic [9:0] reps;
    logic       fixed;
    rsp_t       rs;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Shadow copy of the stack contents
  logic [TAG_W-1:0] shadow_tag [STACK_DEPTH];
  logic [PAY_W-1:0] shadow_pay [STACK_DEPTH];
  int               shadow_size;

  rsp_t     pending_rsp_q [$];
  dir_row_t dir_rows [$];

  int fail_count;
  int cycle_count;
  int send_idle_pct;
  int rsp_stall_pct;
  int hold_requests;
  int hold_served;

  tagged_value_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic req_t mk_req(cmd_e cmd, logic [TAG_W-1:0] tag, logic [PAY_W-1:0] pay,
                                  logic [COUNT_W-1:0] count, logic [INDEX_W-1:0] depth,
                                  logic [TAG_W-1:0] etag, logic strict);
    req_t r;
    r.cmd          = cmd;
    r.push_tag     = tag;
    r.push_payload = pay;
    r.pop_count    = count;
    r.depth_index  = depth;
    r.expected_tag = etag;
    r.strict_check = strict;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(status_e st, logic [TAG_W-1:0] tag, logic [PAY_W-1:0] pay,
                                  logic match, logic [COUNT_W-1:0] popped,
                                  logic [COUNT_W-1:0] size);
    rsp_t o;
    o.status       = st;
    o.read_tag     = tag;
    o.read_payload = pay;
    o.tag_matches  = match;
    o.popped_count = popped;
    o.size_after   = size;
    return o;
  endfunction

  function automatic void add_row(req_t rq, int reps, bit fixed, rsp_t rs);
    dir_row_t row;
    row.rq    = rq;
    row.reps  = 10'(reps);
    row.fixed = fixed;
    row.rs    = rs;
    dir_rows.push_back(row);
  endfunction

  function automatic rsp_t predict_stack(req_t r);
    rsp_t o;
    int   n;
    int   idx;
    o = '0;
    o.status = ST_OK;
    case (r.cmd)
      CMD_PUSH: begin
        if (shadow_size >= STACK_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          shadow_tag[shadow_size] = r.push_tag;
          shadow_pay[shadow_size] = r.push_payload;
          shadow_size++;
        end
      end
      CMD_POP: begin
        n = (int'(r.pop_count) < shadow_size) ? int'(r.pop_count) : shadow_size;
        shadow_size -= n;
        o.popped_count = COUNT_W'(n);
      end
      CMD_PEEK: begin
        if (int'(r.depth_index) >= shadow_size) begin
          o.status = ST_RANGE;
        end else begin
          idx = shadow_size - 1 - int'(r.depth_index);
          if (shadow_tag[idx] != r.expected_tag && r.strict_check) begin
            o.status = ST_TYPE;
          end else begin
            o.read_tag     = shadow_tag[idx];
            o.read_payload = shadow_pay[idx];
            o.tag_matches  = (shadow_tag[idx] == r.expected_tag);
          end
        end
      end
      default: begin
        shadow_size = 0;
      end
    endcase
    o.size_after = COUNT_W'(shadow_size);
    return o;
  endfunction

  function automatic req_t rand_req(int push_w);
    req_t r;
    int   pick;
    r.cmd          = CMD_PUSH;
    r.push_tag     = TAG_W'($urandom);
    r.push_payload = {$urandom, $urandom};
    r.pop_count    = COUNT_W'($urandom_range(256));
    r.depth_index  = INDEX_W'($urandom);
    r.expected_tag = TAG_W'($urandom);
    r.strict_check = 1'($urandom);
    case ($urandom_range(15))
      0: r.push_payload = '0;
      1: r.push_payload = '1;
      2: r.push_payload = {1'b1, {(PAY_W-1){1'b0}}};
      default: ;
    endcase
    pick = $urandom_range(99);
    if (pick < push_w) begin
      r.cmd = CMD_PUSH;
    end else if (pick >= 99) begin
      r.cmd = CMD_CLEAR;
    end else if ($urandom_range(2) == 0) begin
      r.cmd = CMD_POP;
      if ($urandom_range(9) != 0) begin
        r.pop_count = COUNT_W'($urandom_range(3));
      end
    end else begin
      r.cmd = CMD_PEEK;
      if (shadow_size > 0 && $urandom_range(3) != 0) begin
        r.depth_index = INDEX_W'($urandom_range(shadow_size - 1));
        if ($urandom_range(1) == 0) begin
          r.expected_tag = shadow_tag[shadow_size - 1 - int'(r.depth_index)];
        end
      end
    end
    return r;
  endfunction

  task automatic check_rsp(rsp_t got, rsp_t exp);
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      fail_count++;
    end
    if (got.read_tag !== exp.read_tag) begin
      $error("read_tag: expected %0d, got %0d", exp.read_tag, got.read_tag);
      fail_count++;
    end
    if (got.read_payload !== exp.read_payload) begin
      $error("read_payload: expected %h, got %h", exp.read_payload, got.read_payload);
      fail_count++;
    end
    if (got.tag_matches !== exp.tag_matches) begin
      $error("tag_matches: expected %0d, got %0d", exp.tag_matches, got.tag_matches);
      fail_count++;
    end
    if (got.popped_count !== exp.popped_count) begin
      $error("popped_count: expected %0d, got %0d", exp.popped_count, got.popped_count);
      fail_count++;
    end
    if (got.size_after !== exp.size_after) begin
      $error("size_after: expected %0d, got %0d", exp.size_after, got.size_after);
      fail_count++;
    end
  endtask

  // Called at a rising edge; returns at the edge that accepts the transaction.
  task automatic offer_request(req_t r, bit use_fixed, rsp_t fixed_rsp);
    rsp_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = predict_stack(r);
    pending_rsp_q.push_back(use_fixed ? fixed_rsp : predicted);
  endtask

  initial begin : rsp_side
    int hold_left;
    hold_left   = 0;
    hold_served = 0;
    rsp_ready   = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("unexpected response transaction");
          fail_count++;
        end else begin
          check_rsp(rsp, pending_rsp_q.pop_front());
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stim
    int      idle_tab [4];
    int      stall_tab [4];
    int      push_w;
    req_t    item;
    rsp_t    none;
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    fail_count    = 0;
    shadow_size   = 0;
    hold_requests = 0;
    send_idle_pct = 8;
    rsp_stall_pct = 8;
    none          = '0;
    idle_tab  = '{0, 77, 0, 8};
    stall_tab = '{0, 0, 77, 8};

    add_row(mk_req(CMD_PEEK, 0, 0, 0, 0, 0, 1), 1, 1, mk_rsp(ST_RANGE, 0, 0, 0, 0, 0));
    add_row(mk_req(CMD_POP, 0, 0, 256, 0, 0, 0), 1, 1, mk_rsp(ST_OK, 0, 0, 0, 0, 0));
    add_row(mk_req(CMD_POP, 7, '1, 0, 255, 7, 1), 1, 1, mk_rsp(ST_OK, 0, 0, 0, 0, 0));
    add_row(mk_req(CMD_PUSH, 7, '1, 0, 0, 0, 0), 1, 1, mk_rsp(ST_OK, 0, 0, 0, 0, 1));
    add_row(mk_req(CMD_PEEK, 0, 0, 0, 0, 7, 1), 1, 1, mk_rsp(ST_OK, 7, '1, 1, 0, 1));
    add_row(mk_req(CMD_PEEK, 0, 0, 0, 0, 0, 1), 1, 1, mk_rsp(ST_TYPE, 0, 0, 0, 0, 1));
    add_row(mk_req(CMD_PEEK, 0, 0, 0, 0, 0, 0), 1, 1, mk_rsp(ST_OK, 7, '1, 0, 0, 1));
    add_row(mk_req(CMD_PEEK, 0, 0, 0, 1, 7, 0), 1, 1, mk_rsp(ST_RANGE, 0, 0, 0, 0, 1));
    add_row(mk_req(CMD_PEEK, 0, 0, 0, 255, 7, 0), 1, 1, mk_rsp(ST_RANGE, 0, 0, 0, 0, 1));
    add_row(mk_req(CMD_PUSH, 0, 0, 0, 0, 0, 0), 1, 1, mk_rsp(ST_OK, 0, 0, 0, 0, 2));
    add_row(mk_req(CMD_PEEK, 3, '1, 0, 0, 0, 1), 1, 1, mk_rsp(ST_OK, 0, 0, 1, 0, 2));
    add_row(mk_req(CMD_POP, 0, 0, 0, 0, 0, 0), 1, 1, mk_rsp(ST_OK, 0, 0, 0, 0, 2));
    add_row(mk_req(CMD_POP, 0, 0, 256, 0, 0, 0), 1, 1, mk_rsp(ST_OK, 0, 0, 0, 2, 0));
    // fill to capacity, tag and payload vary per entry
    add_row(mk_req(CMD_PUSH, 1, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 0), STACK_DEPTH, 0, none);
    add_row(mk_req(CMD_PUSH, 6, 64'h8000_0000_0000_0000, 0, 0, 0, 0), 1, 1,
            mk_rsp(ST_FULL, 0, 0, 0, 0, 256));
    add_row(mk_req(CMD_PEEK, 0, 0, 0, 255, 1, 1), 1, 0, none);
    add_row(mk_req(CMD_PEEK, 0, 0, 0, 0, 0, 0), 1, 0, none);
    add_row(mk_req(CMD_PEEK, 0, 0, 0, 128, 5, 1), 1, 0, none);
    add_row(mk_req(CMD_POP, 0, 0, 1, 0, 0, 0), 1, 1, mk_rsp(ST_OK, 0, 0, 0, 1, 255));
    add_row(mk_req(CMD_PUSH, 2, 64'h8000_0000_0000_0000, 0, 0, 0, 0), 1, 1,
            mk_rsp(ST_OK, 0, 0, 0, 0, 256));
    add_row(mk_req(CMD_PEEK, 0, 0, 0, 0, 2, 1), 1, 1,
            mk_rsp(ST_OK, 2, 64'h8000_0000_0000_0000, 1, 0, 256));
    add_row(mk_req(CMD_CLEAR, 7, '1, 256, 255, 7, 1), 1, 1, mk_rsp(ST_OK, 0, 0, 0, 0, 0));
    add_row(mk_req(CMD_PEEK, 0, 0, 0, 0, 0, 0), 1, 1, mk_rsp(ST_RANGE, 0, 0, 0, 0, 0));
    add_row(mk_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1, 1, mk_rsp(ST_OK, 0, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      for (int k = 0; k < int'(dir_rows[i].reps); k++) begin
        item = dir_rows[i].rq;
        if (dir_rows[i].reps > 1) begin
          item.push_tag     = dir_rows[i].rq.push_tag + TAG_W'(k);
          item.push_payload = dir_rows[i].rq.push_payload ^ (64'(k) * 64'h9E37_79B9_7F4A_7C15);
        end
        offer_request(item, dir_rows[i].fixed, dir_rows[i].rs);
      end
    end

    push_w = 55;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      rsp_stall_pct = stall_tab[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 100 == 0) begin
          case ($urandom_range(2))
            0: push_w = 92;
            1: push_w = 55;
            default: push_w = 25;
          endcase
        end
        // long receiver hold-off while requests keep coming
        if ((ph == 0 || ph == 3) && n == 40) begin
          hold_requests++;
        end
        offer_request(rand_req(push_w), 1'b0, none);
      end
    end

    req_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
